FILE: rtl/dofx_pkg.sv
// ---------------------------------------------------------------------------
// dofx_pkg: shared types and constants of the DHCP option field extractor
// Option codes, field targets, the front-to-back queue entry and the result
// packing widths.
// ---------------------------------------------------------------------------
package dofx_pkg;

    // Option codes
    localparam logic [7:0] OPT_PAD     = 8'd0;
    localparam logic [7:0] OPT_MASK    = 8'd1;
    localparam logic [7:0] OPT_ROUTER  = 8'd3;
    localparam logic [7:0] OPT_TIME    = 8'd4;
    localparam logic [7:0] OPT_DNS     = 8'd6;
    localparam logic [7:0] OPT_LEASE   = 8'd51;
    localparam logic [7:0] OPT_MSGTYPE = 8'd53;
    localparam logic [7:0] OPT_SERVER  = 8'd54;
    localparam logic [7:0] OPT_END     = 8'd255;

    // Message type values
    localparam logic [7:0] MSG_OFFER = 8'h02;
    localparam logic [7:0] MSG_ACK   = 8'h05;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_OFFER = 2'd1,
        KIND_ACK   = 2'd2
    } kind_t;

    // Where a finished option lands in the back end
    typedef enum logic [2:0] {
        TGT_NONE   = 3'd0,
        TGT_TYPE   = 3'd1,
        TGT_MASK   = 3'd2,
        TGT_ROUTER = 3'd3,
        TGT_TIME   = 3'd4,
        TGT_DNS    = 3'd5,
        TGT_LEASE  = 3'd6,
        TGT_SERVER = 3'd7
    } tgt_t;

    // One queue entry: an option commit, an end-of-message marker, or both
    typedef struct packed {
        logic        commit;
        tgt_t        tgt;
        logic [31:0] word;
        logic        last;
        logic        trunc;
    } q_entry_t;

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam int IN_W   = 8;
    localparam int OUT_W  = 208;   // 202 field bits padded to whole bytes
    localparam int USER_W = 2;

    function automatic tgt_t classify(input logic [7:0] code);
        tgt_t t;
        case (code)
            OPT_MSGTYPE: t = TGT_TYPE;
            OPT_MASK:    t = TGT_MASK;
            OPT_ROUTER:  t = TGT_ROUTER;
            OPT_TIME:    t = TGT_TIME;
            OPT_DNS:     t = TGT_DNS;
            OPT_LEASE:   t = TGT_LEASE;
            OPT_SERVER:  t = TGT_SERVER;
            default:     t = TGT_NONE;
        endcase
        return t;
    endfunction

endpackage

FILE: rtl/dofx_front.sv
// ---------------------------------------------------------------------------
// dofx_front: option walker
// Follows the code / length / value framing one byte per beat, assembles
// the big-endian value word and pushes finished options and end-of-message
// markers into the queue.
// ---------------------------------------------------------------------------
module dofx_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         opt_byte,
    input  logic               is_last,
    input  logic               q_full,
    output logic               q_push,
    output dofx_pkg::q_entry_t q_data
);
    import dofx_pkg::*;

    typedef enum logic [1:0] {
        PH_CODE = 2'd0,
        PH_LEN  = 2'd1,
        PH_VAL  = 2'd2
    } phase_t;

    phase_t      phase_reg,  phase_next;
    tgt_t        tgt_reg,    tgt_next;
    logic [7:0]  left_reg,   left_next;
    logic [2:0]  pos_reg,    pos_next;
    logic [31:0] word_reg,   word_next;
    logic        ended_reg,  ended_next;
    logic        commit;
    logic        beat;

    assign in_ready = !q_full;
    assign beat     = in_valid && in_ready;

    always_comb
    begin
        phase_next = phase_reg;
        tgt_next   = tgt_reg;
        left_next  = left_reg;
        pos_next   = pos_reg;
        word_next  = word_reg;
        ended_next = ended_reg;
        commit     = 1'b0;
        if (!ended_reg)
        begin
            case (phase_reg)
                PH_CODE:
                begin
                    if (opt_byte == OPT_END)
                        ended_next = 1'b1;
                    else if (opt_byte != OPT_PAD)
                    begin
                        tgt_next   = classify(opt_byte);
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    left_next = opt_byte;
                    pos_next  = 3'd0;
                    word_next = 32'd0;
                    if (opt_byte == 8'd0)
                    begin
                        commit     = 1'b1;
                        phase_next = PH_CODE;
                    end
                    else
                        phase_next = PH_VAL;
                end
                PH_VAL:
                begin
                    // fill byte lanes from the top; bytes past the fourth are dropped
                    for (int i = 0; i < 4; i++)
                    begin
                        if (pos_reg == 3'(i))
                            word_next[31 - 8*i -: 8] = opt_byte;
                    end
                    if (!pos_reg[2])
                        pos_next = pos_reg + 3'd1;
                    left_next = left_reg - 8'd1;
                    if (left_reg == 8'd1)
                    begin
                        commit     = 1'b1;
                        phase_next = PH_CODE;
                    end
                end
                default:
                begin
                    phase_next = PH_CODE;
                end
            endcase
        end
    end

    always_comb
    begin
        q_data.commit = commit && (tgt_next != TGT_NONE);
        q_data.tgt    = tgt_next;
        q_data.word   = word_next;
        q_data.last   = is_last;
        q_data.trunc  = !ended_next && (phase_next != PH_CODE);
    end

    assign q_push = beat && (q_data.commit || is_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_CODE;
            tgt_reg   <= TGT_NONE;
            left_reg  <= 8'd0;
            pos_reg   <= 3'd0;
            word_reg  <= 32'd0;
            ended_reg <= 1'b0;
        end
        else if (beat)
        begin
            if (is_last)
            begin
                phase_reg <= PH_CODE;
                tgt_reg   <= TGT_NONE;
                left_reg  <= 8'd0;
                pos_reg   <= 3'd0;
                word_reg  <= 32'd0;
                ended_reg <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                tgt_reg   <= tgt_next;
                left_reg  <= left_next;
                pos_reg   <= pos_next;
                word_reg  <= word_next;
                ended_reg <= ended_next;
            end
        end
    end

endmodule

FILE: rtl/dofx_queue.sv
// ---------------------------------------------------------------------------
// dofx_queue: short entry queue
// Two-entry register queue between the option walker and the field store.
// ---------------------------------------------------------------------------
module dofx_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  dofx_pkg::q_entry_t push_data,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output dofx_pkg::q_entry_t head
);
    import dofx_pkg::*;

    q_entry_t           mem_reg [QDEPTH];
    logic [QAW-1:0]     wr_ptr_reg;
    logic [QAW-1:0]     rd_ptr_reg;
    logic [QCW-1:0]     count_reg;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == QCW'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

FILE: rtl/dofx_back.sv
// ---------------------------------------------------------------------------
// dofx_back: field store and result register
// Applies finished options to the field registers and, on an end-of-message
// entry, loads the result register and clears the fields.
// ---------------------------------------------------------------------------
module dofx_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    input  dofx_pkg::q_entry_t           q_head,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [dofx_pkg::OUT_W-1:0]   out_data,
    output logic [dofx_pkg::USER_W-1:0]  out_user
);
    import dofx_pkg::*;

    logic [7:0]  type_reg,   type_next;
    logic [31:0] mask_reg,   mask_next;
    logic [31:0] router_reg, router_next;
    logic [31:0] time_reg,   time_next;
    logic [31:0] dns_reg,    dns_next;
    logic [31:0] lease_reg,  lease_next;
    logic [31:0] server_reg, server_next;
    logic        sflag_reg,  sflag_next;
    logic        ovalid_reg;
    logic [OUT_W-1:0]  odata_reg;
    kind_t       okind_reg,  kind_next;
    logic        emit;

    assign q_pop = !q_empty && (!q_head.last || !ovalid_reg || out_ready);
    assign emit  = q_pop && q_head.last;

    always_comb
    begin
        type_next   = type_reg;
        mask_next   = mask_reg;
        router_next = router_reg;
        time_next   = time_reg;
        dns_next    = dns_reg;
        lease_next  = lease_reg;
        server_next = server_reg;
        sflag_next  = sflag_reg;
        if (q_head.commit)
        begin
            case (q_head.tgt)
                TGT_TYPE:   type_next   = q_head.word[31:24];
                TGT_MASK:   mask_next   = q_head.word;
                TGT_ROUTER: router_next = q_head.word;
                TGT_TIME:   time_next   = q_head.word;
                TGT_DNS:    dns_next    = q_head.word;
                TGT_LEASE:  lease_next  = q_head.word;
                TGT_SERVER:
                begin
                    if (!sflag_reg)
                    begin
                        server_next = q_head.word;
                        sflag_next  = 1'b1;
                    end
                end
                default:
                begin
                    type_next = type_reg;
                end
            endcase
        end
        if (type_next == MSG_OFFER)
            kind_next = KIND_OFFER;
        else if (type_next == MSG_ACK)
            kind_next = KIND_ACK;
        else
            kind_next = KIND_OTHER;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_reg   <= 8'd0;
            mask_reg   <= 32'd0;
            router_reg <= 32'd0;
            time_reg   <= 32'd0;
            dns_reg    <= 32'd0;
            lease_reg  <= 32'd0;
            server_reg <= 32'd0;
            sflag_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                type_reg   <= 8'd0;
                mask_reg   <= 32'd0;
                router_reg <= 32'd0;
                time_reg   <= 32'd0;
                dns_reg    <= 32'd0;
                lease_reg  <= 32'd0;
                server_reg <= 32'd0;
                sflag_reg  <= 1'b0;
                ovalid_reg <= 1'b1;
            end
            else
            begin
                if (q_pop)
                begin
                    type_reg   <= type_next;
                    mask_reg   <= mask_next;
                    router_reg <= router_next;
                    time_reg   <= time_next;
                    dns_reg    <= dns_next;
                    lease_reg  <= lease_next;
                    server_reg <= server_next;
                    sflag_reg  <= sflag_next;
                end
                if (out_ready)
                    ovalid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            okind_reg <= kind_next;
            odata_reg <= {6'd0, q_head.trunc, sflag_next, server_next, lease_next,
                          dns_next, time_next, router_next, mask_next, type_next};
        end
    end

    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;
    assign out_user  = okind_reg;

endmodule

FILE: rtl/dhcp_option_field_extractor_core.sv
// ---------------------------------------------------------------------------
// dhcp_option_field_extractor_core: DHCP options area field extractor
// Walks the options area of a received DHCP message as code / length /
// value triples and reports the extracted fields on the last byte.
// ---------------------------------------------------------------------------
//
//  Channel  Dir  Payload                                   Beat
//  -------  ---  ----------------------------------------  ------------------
//  s_*      in   tdata = opt_byte, tlast = is_last         one options byte
//  m_*      out  tdata = fields (see port), tuser = kind   one message result
//
//  Throughput: one options byte per clock while s_tready is high. m_tvalid
//  rises once the beat carrying s_tlast has passed through the queue and
//  loaded the result register. Pad (0) takes one byte; end (255) stops
//  parsing until the last byte. Reset clears all parse state and the field
//  store. A stalled m_tready holds the result while the walker keeps taking
//  bytes; s_tready drops only once the two-entry queue is full, which
//  happens when an end-of-message entry meets a result still waiting and a
//  further entry is pushed behind it.
//
module dhcp_option_field_extractor_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // options byte stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dofx_pkg::IN_W-1:0]           s_tdata,  // [7:0] opt_byte
    input  logic                                s_tlast,  // is_last
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] type_code, [39:8] subnet_mask, [71:40] router_addr,
    // [103:72] time_server, [135:104] dns_server, [167:136] lease_secs,
    // [199:168] server_id, [200] server_id_found, [201] truncated,
    // [207:202] zero
    output logic [dofx_pkg::OUT_W-1:0]          m_tdata,
    output logic [dofx_pkg::USER_W-1:0]         m_tuser   // [1:0] kind
);
    import dofx_pkg::*;

    q_entry_t q_in;
    q_entry_t q_head;
    logic     q_push;
    logic     q_pop;
    logic     q_full;
    logic     q_empty;

    // Front: framing walker and value assembly
    dofx_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .opt_byte (s_tdata),
        .is_last  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    // Decoupling queue of finished options and end markers
    dofx_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    // Back: field store and result register
    dofx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_user  (m_tuser)
    );

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: testbench for dhcp_option_field_extractor_core
// Feeds DHCP options areas byte by byte, mirrors the option walk in a
// behavioral field extractor and checks every result beat field by field.
// Directed messages come first, then random messages (mostly well-formed
// option lists, some cut short, some plain noise) with random stalls on both
// sides and long receiver hold-offs that back the block up to its input.
// ---------------------------------------------------------------------------
module tb;
    import dofx_pkg::*;

    localparam int unsigned RESET_CYCLES  = 10;
    localparam int unsigned RANDOM_BEATS  = 1550;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned DRAIN_LIMIT   = 20000;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned MAX_REPORTS   = 10;

    localparam logic MORE = 1'b0;
    localparam logic LAST = 1'b1;

    // option code nobody decodes, used to leave a value pending at the end
    localparam logic [7:0] OPT_UNUSED = 8'd99;

    typedef enum logic [1:0] {
        WALK_CODE,
        WALK_LEN,
        WALK_VALUE
    } walk_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  type_code;
        logic [31:0] subnet_mask;
        logic [31:0] router_addr;
        logic [31:0] time_server;
        logic [31:0] dns_server;
        logic [31:0] lease_secs;
        logic [31:0] server_id;
        logic        server_id_found;
        logic        truncated;
    } dhcp_fields_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata  = '0;
    logic                s_tlast  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;
    logic [USER_W-1:0]   m_tuser;

    // extractor state
    walk_t       walk_phase;
    logic [7:0]  opt_code;
    logic [7:0]  len_left;
    logic [2:0]  val_count;
    logic [31:0] val_word;
    logic [7:0]  hold_type;
    logic [31:0] hold_mask;
    logic [31:0] hold_router;
    logic [31:0] hold_time;
    logic [31:0] hold_dns;
    logic [31:0] hold_lease;
    logic [31:0] hold_server;
    logic        server_seen;
    logic        end_seen;

    dhcp_fields_t expected_fields[$];
    dhcp_fields_t directed_results[0:4];
    logic [8:0]   msg_beats[$];

    int unsigned fail_count     = 0;
    int unsigned accepted_beats = 0;
    int unsigned cycle_count    = 0;
    bit          quiet_sender   = 1'b0;
    bit          hold_off       = 1'b0;

    // {tlast, byte}; five messages, each closed by a LAST beat
    logic [8:0] directed_beats[0:24] = '{
        {LAST, OPT_END},                                    // empty, end only
        {LAST, OPT_PAD},                                    // empty, pad only
        {MORE, OPT_MSGTYPE}, {MORE, 8'd1}, {MORE, MSG_ACK},
        {MORE, OPT_LEASE}, {MORE, 8'd4},
        {MORE, 8'hFF}, {MORE, 8'hFF}, {MORE, 8'hFF}, {MORE, 8'hFF},
        {MORE, OPT_SERVER}, {MORE, 8'd2}, {MORE, 8'hC0}, {MORE, 8'hA8},
        {MORE, OPT_END}, {LAST, 8'h7F},                     // junk after end
        {MORE, OPT_ROUTER}, {MORE, 8'd0}, {LAST, OPT_DNS},  // ends on a code
        {MORE, OPT_MSGTYPE}, {MORE, 8'd1}, {MORE, MSG_OFFER},
        {MORE, OPT_UNUSED}, {LAST, 8'd4}                    // ends on a length
    };

    dhcp_option_field_extractor_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic dhcp_fields_t make_fields(
        input kind_t k, input logic [7:0] t, input logic [31:0] mask,
        input logic [31:0] router, input logic [31:0] tsrv, input logic [31:0] dns,
        input logic [31:0] lease, input logic [31:0] sid, input logic found,
        input logic trunc);
        dhcp_fields_t f;
        f.kind            = k;
        f.type_code       = t;
        f.subnet_mask     = mask;
        f.router_addr     = router;
        f.time_server     = tsrv;
        f.dns_server      = dns;
        f.lease_secs      = lease;
        f.server_id       = sid;
        f.server_id_found = found;
        f.truncated       = trunc;
        return f;
    endfunction

    // mostly back to back, sometimes a short gap, rarely a long gap
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void clear_walker();
        walk_phase  = WALK_CODE;
        opt_code    = '0;
        len_left    = '0;
        val_count   = '0;
        val_word    = '0;
        hold_type   = '0;
        hold_mask   = '0;
        hold_router = '0;
        hold_time   = '0;
        hold_dns    = '0;
        hold_lease  = '0;
        hold_server = '0;
        server_seen = 1'b0;
        end_seen    = 1'b0;
    endfunction

    // Short values are left-aligned (missing low bytes read as zero).
    function automatic void store_option();
        logic [31:0] w;
        w = '0;
        if (val_count >= 3'd4)
            w = val_word;
        else if (val_count != 3'd0)
            w = val_word << (8 * (4 - val_count));
        case (opt_code)
            OPT_MSGTYPE: hold_type   = w[31:24];
            OPT_MASK:    hold_mask   = w;
            OPT_ROUTER:  hold_router = w;
            OPT_TIME:    hold_time   = w;
            OPT_DNS:     hold_dns    = w;
            OPT_LEASE:   hold_lease  = w;
            OPT_SERVER:
            begin
                // first server identifier wins
                if (!server_seen)
                begin
                    hold_server = w;
                    server_seen = 1'b1;
                end
            end
            default: ;
        endcase
    endfunction

    // One options byte through the walker; a last byte yields the field set.
    function automatic void extract_byte(input logic [7:0] b, input logic last,
                                         output bit done, output dhcp_fields_t res);
        kind_t k;
        done = 1'b0;
        res  = '0;
        if (!end_seen)
        begin
            case (walk_phase)
                WALK_CODE:
                begin
                    if (b == OPT_END)
                        end_seen = 1'b1;
                    else if (b != OPT_PAD)
                    begin
                        opt_code   = b;
                        walk_phase = WALK_LEN;
                    end
                end
                WALK_LEN:
                begin
                    len_left  = b;
                    val_count = '0;
                    val_word  = '0;
                    if (b == 8'd0)
                    begin
                        store_option();
                        walk_phase = WALK_CODE;
                    end
                    else
                        walk_phase = WALK_VALUE;
                end
                default:
                begin
                    // bytes past the fourth are skipped
                    if (val_count < 3'd4)
                    begin
                        val_word  = {val_word[23:0], b};
                        val_count = val_count + 3'd1;
                    end
                    len_left = len_left - 8'd1;
                    if (len_left == 8'd0)
                    begin
                        store_option();
                        walk_phase = WALK_CODE;
                    end
                end
            endcase
        end
        if (last)
        begin
            if (hold_type == MSG_OFFER)
                k = KIND_OFFER;
            else if (hold_type == MSG_ACK)
                k = KIND_ACK;
            else
                k = KIND_OTHER;
            res = make_fields(k, hold_type, hold_mask, hold_router, hold_time,
                              hold_dns, hold_lease, hold_server, server_seen,
                              !end_seen && walk_phase != WALK_CODE);
            done = 1'b1;
            clear_walker();
        end
    endfunction

    task automatic report_failure(input string what);
        if (fail_count < MAX_REPORTS)
            $display("  mismatch at %0t: %s", $time, what);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
            report_failure($sformatf("%s expected %h got %h", name, want, got));
    endtask

    // Drives one beat at the falling edge, waits for the handshake and
    // predicts the result once the beat is taken.
    task automatic send_beat(input logic [8:0] beat, input bit typed,
                             input dhcp_fields_t typed_want, output bit produced);
        int unsigned gap;
        dhcp_fields_t want;
        gap = quiet_sender ? 0 : pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat[7:0];
        s_tlast  <= beat[8];
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        accepted_beats++;
        extract_byte(beat[7:0], beat[8], produced, want);
        if (produced)
            expected_fields.push_back(typed ? typed_want : want);
        @(negedge clk);
    endtask

    // Random options area: mostly well-formed option lists, some cut short
    // at a random point, some raw noise.
    task automatic build_message();
        logic [7:0]  known_codes[0:6];
        logic [7:0]  code;
        logic [7:0]  b;
        int unsigned style;
        int unsigned n;
        int unsigned len;
        int unsigned r;
        known_codes = '{OPT_MASK, OPT_ROUTER, OPT_TIME, OPT_DNS,
                        OPT_LEASE, OPT_MSGTYPE, OPT_SERVER};
        msg_beats.delete();
        style = $urandom_range(0, 99);
        if (style >= 90)
        begin
            n = $urandom_range(1, 30);
            repeat (n) msg_beats.push_back({MORE, 8'($urandom)});
        end
        else
        begin
            n = $urandom_range(0, 6);
            repeat (n)
            begin
                if ($urandom_range(0, 9) == 0)
                    msg_beats.push_back({MORE, OPT_PAD});
                else
                begin
                    if ($urandom_range(0, 9) < 8)
                        code = known_codes[$urandom_range(0, 6)];
                    else
                        code = 8'($urandom_range(1, 254));
                    r = $urandom_range(0, 99);
                    if (r < 60)
                        len = (code == OPT_MSGTYPE) ? 1 : 4;
                    else if (r < 88)
                        len = $urandom_range(0, 8);
                    else if (r < 99)
                        len = $urandom_range(9, 40);
                    else
                        len = $urandom_range(128, 255);
                    msg_beats.push_back({MORE, code});
                    msg_beats.push_back({MORE, 8'(len)});
                    for (int i = 0; i < len; i++)
                    begin
                        b = 8'($urandom);
                        if (code == OPT_MSGTYPE && i == 0 && $urandom_range(0, 1) == 1)
                            b = $urandom_range(0, 1) ? MSG_OFFER : MSG_ACK;
                        msg_beats.push_back({MORE, b});
                    end
                end
            end
            if ($urandom_range(0, 9) < 6)
            begin
                msg_beats.push_back({MORE, OPT_END});
                n = $urandom_range(0, 3);
                repeat (n) msg_beats.push_back({MORE, 8'($urandom)});
            end
            // broken message: stop somewhere inside
            if (style >= 75 && msg_beats.size() > 1)
            begin
                n = $urandom_range(1, msg_beats.size() - 1);
                while (msg_beats.size() > n)
                    msg_beats.delete(msg_beats.size() - 1);
            end
        end
        if (msg_beats.size() == 0)
            msg_beats.push_back({MORE, 8'($urandom)});
        msg_beats[msg_beats.size() - 1][8] = LAST;
    endtask

    initial
    begin : stimulus
        int unsigned  msg_idx;
        int unsigned  random_beats;
        bit           produced;
        dhcp_fields_t no_want;
        msg_idx        = 0;
        random_beats   = 0;
        no_want        = '0;
        clear_walker();
        directed_results[0] = make_fields(KIND_OTHER, 8'd0, '0, '0, '0, '0, '0, '0,
                                          1'b0, 1'b0);
        directed_results[1] = directed_results[0];
        directed_results[2] = make_fields(KIND_ACK, MSG_ACK, '0, '0, '0, '0,
                                          32'hFFFF_FFFF, 32'hC0A8_0000, 1'b1, 1'b0);
        directed_results[3] = make_fields(KIND_OTHER, 8'd0, '0, '0, '0, '0, '0, '0,
                                          1'b0, 1'b1);
        directed_results[4] = make_fields(KIND_OFFER, MSG_OFFER, '0, '0, '0, '0, '0,
                                          '0, 1'b0, 1'b1);
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_beats[row])
        begin
            send_beat(directed_beats[row], 1'b1, directed_results[msg_idx], produced);
            if (directed_beats[row][8])
                msg_idx++;
        end

        while (random_beats < RANDOM_BEATS)
        begin
            build_message();
            // some messages go through with no sender gaps at all
            quiet_sender = ($urandom_range(0, 5) == 0);
            foreach (msg_beats[i])
            begin
                send_beat(msg_beats[i], 1'b0, no_want, produced);
                random_beats++;
            end
        end
        s_tvalid <= 1'b0;

        for (int n = 0; n < DRAIN_LIMIT && expected_fields.size() != 0; n++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_fields.size() != 0)
            report_failure($sformatf("%0d result beats never arrived",
                                     expected_fields.size()));
        if (fail_count == 0)
            $display("[dhcp_option_field_extractor_core] OK");
        else
            $display("[dhcp_option_field_extractor_core] ERROR");
        $finish;
    end

    // Long receiver hold-offs: results pile up until s_tready drops.
    initial
    begin : hold_window
        wait (accepted_beats >= 400);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
        wait (accepted_beats >= 1100);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin : result_sink
        int unsigned stall_left;
        int unsigned steady_left;
        stall_left  = 0;
        steady_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
                m_tready <= 1'b0;
            else if (stall_left != 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (steady_left != 0)
                    steady_left--;
                else if ($urandom_range(0, 9) == 0)
                    steady_left = $urandom_range(20, 80);
                else if ($urandom_range(0, 2) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Result beat checker: oldest expectation first.
    always @(posedge clk)
    begin : result_check
        dhcp_fields_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_fields.size() == 0)
                report_failure($sformatf("unexpected result beat %h kind %0d",
                                         m_tdata, m_tuser));
            else
            begin
                want = expected_fields.pop_front();
                check_field("kind", 32'(want.kind), 32'(m_tuser));
                check_field("type_code", 32'(want.type_code), 32'(m_tdata[7:0]));
                check_field("subnet_mask", want.subnet_mask, m_tdata[39:8]);
                check_field("router_addr", want.router_addr, m_tdata[71:40]);
                check_field("time_server", want.time_server, m_tdata[103:72]);
                check_field("dns_server", want.dns_server, m_tdata[135:104]);
                check_field("lease_secs", want.lease_secs, m_tdata[167:136]);
                check_field("server_id", want.server_id, m_tdata[199:168]);
                check_field("server_id_found", 32'(want.server_id_found),
                            32'(m_tdata[200]));
                check_field("truncated", 32'(want.truncated), 32'(m_tdata[201]));
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[dhcp_option_field_extractor_core] ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/dofx_pkg.sv
rtl/dofx_front.sv
rtl/dofx_queue.sv
rtl/dofx_back.sv
rtl/dhcp_option_field_extractor_core.sv
verif/tb.sv
